// File: rtl/bbd_pkg.sv
`timescale 1ns / 1ps

package bbd_pkg;

  // fixed field widths
  localparam int PIXEL_BITS    = 8;
  localparam int COORD_BITS    = 12;
  localparam int SIZE_BITS     = 13;
  localparam int COUNT_LIMIT   = 4096;
  localparam int DEF_MAX_WIDTH = 4096;

  // configuration port
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MOSAIC_LAYOUT = 2'd2;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd480;

  // colour filter layouts
  localparam logic [1:0] LAYOUT_RGGB = 2'd0;
  localparam logic [1:0] LAYOUT_BGGR = 2'd1;
  localparam logic [1:0] LAYOUT_GRBG = 2'd2;
  localparam logic [1:0] LAYOUT_GBRG = 2'd3;

  // one result beat
  typedef struct packed {
    logic [PIXEL_BITS-1:0] red;
    logic [PIXEL_BITS-1:0] green;
    logic [PIXEL_BITS-1:0] blue;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic                  frame_done;
  } bbd_result_t;

  // output queue status
  typedef struct packed {
    logic       valid;
    logic [1:0] count;
  } bbd_fifo_status_t;

endpackage

// File: rtl/bbd_in_if.sv
`timescale 1ns / 1ps

interface bbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_value;
  logic       frame_start;

  modport source (output valid, output raw_value, output frame_start, input ready);
  modport sink   (input valid, input raw_value, input frame_start, output ready);
endinterface

// File: rtl/bbd_out_if.sv
`timescale 1ns / 1ps

interface bbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] column;
  logic [11:0] row;
  logic        frame_done;

  modport source (output valid, output red, output green, output blue,
                  output column, output row, output frame_done, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input column, input row, input frame_done, output ready);
endinterface

// File: rtl/bbd_ram.sv
`timescale 1ns / 1ps

module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bbd_out_fifo.sv
`timescale 1ns / 1ps

module bbd_out_fifo import bbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bbd_result_t      push_data,
  input  logic             pop,
  output bbd_result_t      head,
  output bbd_fifo_status_t status
);

  localparam logic [1:0] LAST_SLOT = 2'd2;

  bbd_result_t slot_r [3];
  logic [1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_pop;

  assign do_pop = pop && (count_r != 2'd0);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign status.valid = (count_r != 2'd0);
  assign status.count = count_r;

endmodule

// File: rtl/bilinear_bayer_demosaic_top.sv
`timescale 1ns / 1ps

// Bilinear Bayer demosaic: raw 8-bit samples enter in raster order, one per clock while
// in_ch.ready is high, and each interior pixel leaves as one R, G, B beat with its column
// and row after the sample at (column+1, row+1) is taken. Border pixels give no beat. One
// line store RAM holds the two previous lines side by side; each sample costs one read and
// one write of it. frame_start puts a sample at (0, 0); otherwise the position wraps by
// frame_width and frame_height (clamped to 3..4096, width also to MAX_WIDTH). The user
// must write sizes and layout over the APB port only while the stream is idle; the block
// does not enforce it. Line store entries not yet written in a frame read as garbage.
module bilinear_bayer_demosaic_top import bbd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  bbd_in_if.sink                   in_ch,
  bbd_out_if.source                out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam int AW           = $clog2(MAX_WIDTH);
  localparam int WIDTH_HI_INT = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
  localparam logic [SIZE_BITS-1:0] WIDTH_HI  = SIZE_BITS'(WIDTH_HI_INT);
  localparam logic [SIZE_BITS-1:0] HEIGHT_HI = SIZE_BITS'(COUNT_LIMIT);
  localparam logic [SIZE_BITS-1:0] SIZE_LO   = SIZE_BITS'(3);
  localparam logic [COORD_BITS-1:0] EDGE     = COORD_BITS'(2);

  // configuration registers
  logic [SIZE_BITS-1:0]    frame_width_r;
  logic [SIZE_BITS-1:0]    frame_height_r;
  logic [1:0]              mosaic_layout_r;
  logic                    cfg_wr;
  logic [REG_IDX_BITS-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= WIDTH_RESET;
      frame_height_r  <= HEIGHT_RESET;
      mosaic_layout_r <= LAYOUT_RGGB;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_pwdata[SIZE_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_pwdata[SIZE_BITS-1:0];
        REG_MOSAIC_LAYOUT: mosaic_layout_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:   cfg_prdata = CFG_DATA_BITS'(frame_width_r);
      REG_FRAME_HEIGHT:  cfg_prdata = CFG_DATA_BITS'(frame_height_r);
      REG_MOSAIC_LAYOUT: cfg_prdata = CFG_DATA_BITS'(mosaic_layout_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // effective frame size
  logic [SIZE_BITS-1:0] eff_w, eff_h;

  always_comb begin
    if (frame_width_r < SIZE_LO) begin
      eff_w = SIZE_LO;
    end else if (frame_width_r > WIDTH_HI) begin
      eff_w = WIDTH_HI;
    end else begin
      eff_w = frame_width_r;
    end
    if (frame_height_r < SIZE_LO) begin
      eff_h = SIZE_LO;
    end else if (frame_height_r > HEIGHT_HI) begin
      eff_h = HEIGHT_HI;
    end else begin
      eff_h = frame_height_r;
    end
  end

  // position of the incoming sample
  logic [COORD_BITS-1:0] column_count_r, column_count_nxt;
  logic [COORD_BITS-1:0] row_count_r, row_count_nxt;
  logic [COORD_BITS-1:0] cx, cy, x0, y0;
  logic [SIZE_BITS-1:0]  y_inc, xn, yn;
  logic                  accept, emit0, done0;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    cx = in_ch.frame_start ? '0 : column_count_r;
    cy = in_ch.frame_start ? '0 : row_count_r;
    if ({1'b0, cx} >= eff_w) begin
      x0    = '0;
      y_inc = {1'b0, cy} + SIZE_BITS'(1);
    end else begin
      x0    = cx;
      y_inc = {1'b0, cy};
    end
    y0    = (y_inc >= eff_h) ? '0 : y_inc[COORD_BITS-1:0];
    emit0 = (x0 >= EDGE) && (y0 >= EDGE);
    done0 = ({1'b0, x0} == eff_w - SIZE_BITS'(1)) && ({1'b0, y0} == eff_h - SIZE_BITS'(1));
    // advance
    xn = {1'b0, x0} + SIZE_BITS'(1);
    yn = {1'b0, y0};
    if (xn >= eff_w) begin
      xn = '0;
      yn = {1'b0, y0} + SIZE_BITS'(1);
      if (yn >= eff_h) begin
        yn = '0;
      end
    end
    column_count_nxt = xn[COORD_BITS-1:0];
    row_count_nxt    = yn[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (accept) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // line store: {older, newer} per column
  logic [AW-1:0]             rd_addr;
  logic [2*PIXEL_BITS-1:0]   ram_rdata, ram_wdata, lines;
  logic                      s1_valid_r;
  logic [AW-1:0]             s1_addr_r;
  logic [PIXEL_BITS-1:0]     s1_raw_r;
  logic                      s1_emit_r, s1_done_r;
  logic [COORD_BITS-1:0]     s1_px_r, s1_py_r;
  logic                      fwd_r;
  logic [2*PIXEL_BITS-1:0]   fwd_data_r;

  assign rd_addr = AW'(x0);

  bbd_ram #(
    .WIDTH (2*PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // forward a write to the same column that lands while it is being read
  assign lines     = fwd_r ? fwd_data_r : ram_rdata;
  assign ram_wdata = {lines[PIXEL_BITS-1:0], s1_raw_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      fwd_r      <= accept && s1_valid_r && (rd_addr == s1_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= ram_wdata;
    if (accept) begin
      s1_addr_r <= rd_addr;
      s1_raw_r  <= in_ch.raw_value;
      s1_emit_r <= emit0;
      s1_done_r <= done0;
      s1_px_r   <= x0 - COORD_BITS'(1);
      s1_py_r   <= y0 - COORD_BITS'(1);
    end
  end

  // 3x3 window, row-major, top row first
  logic [PIXEL_BITS-1:0] win_r [9];
  logic [PIXEL_BITS-1:0] win_nxt [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]   = win_r[i*3+1];
      win_nxt[i*3+1] = win_r[i*3+2];
    end
    win_nxt[2] = lines[2*PIXEL_BITS-1:PIXEL_BITS];
    win_nxt[5] = lines[PIXEL_BITS-1:0];
    win_nxt[8] = s1_raw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_valid_r) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // interpolation on the updated window
  logic [PIXEL_BITS+1:0] cross_sum, diag_sum;
  logic [PIXEL_BITS:0]   horiz_sum, vert_sum;
  logic [PIXEL_BITS-1:0] centre, cross_avg, diag, horiz, vert;
  logic                  red_x, red_y, at_red_col, at_red_row;
  bbd_result_t           result;

  assign red_x = (mosaic_layout_r == LAYOUT_BGGR) || (mosaic_layout_r == LAYOUT_GRBG);
  assign red_y = (mosaic_layout_r == LAYOUT_BGGR) || (mosaic_layout_r == LAYOUT_GBRG);
  assign at_red_col = (s1_px_r[0] == red_x);
  assign at_red_row = (s1_py_r[0] == red_y);

  always_comb begin
    centre    = win_nxt[4];
    cross_sum = (PIXEL_BITS+2)'(win_nxt[1]) + (PIXEL_BITS+2)'(win_nxt[7])
              + (PIXEL_BITS+2)'(win_nxt[3]) + (PIXEL_BITS+2)'(win_nxt[5]);
    diag_sum  = (PIXEL_BITS+2)'(win_nxt[0]) + (PIXEL_BITS+2)'(win_nxt[2])
              + (PIXEL_BITS+2)'(win_nxt[6]) + (PIXEL_BITS+2)'(win_nxt[8]);
    horiz_sum = (PIXEL_BITS+1)'(win_nxt[3]) + (PIXEL_BITS+1)'(win_nxt[5]);
    vert_sum  = (PIXEL_BITS+1)'(win_nxt[1]) + (PIXEL_BITS+1)'(win_nxt[7]);
    cross_avg = cross_sum[PIXEL_BITS+1:2];
    diag      = diag_sum[PIXEL_BITS+1:2];
    horiz     = horiz_sum[PIXEL_BITS:1];
    vert      = vert_sum[PIXEL_BITS:1];

    priority if (at_red_col && at_red_row) begin
      result.red = centre; result.green = cross_avg; result.blue = diag;
    end else if (!at_red_col && !at_red_row) begin
      result.blue = centre; result.green = cross_avg; result.red = diag;
    end else if (at_red_row) begin
      result.green = centre; result.red = horiz; result.blue = vert;
    end else begin
      result.green = centre; result.blue = horiz; result.red = vert;
    end
    result.column     = s1_px_r;
    result.row        = s1_py_r;
    result.frame_done = s1_done_r;
  end

  // output queue: room for every beat in flight
  bbd_fifo_status_t fifo_st;
  bbd_result_t      head;
  logic [2:0]       in_flight;

  bbd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r && s1_emit_r),
    .push_data (result),
    .pop       (out_ch.ready),
    .head      (head),
    .status    (fifo_st)
  );

  assign in_flight   = {1'b0, fifo_st.count} + {2'b00, s1_valid_r};
  assign in_ch.ready = (in_flight <= 3'd2);

  assign out_ch.valid      = fifo_st.valid;
  assign out_ch.red        = head.red;
  assign out_ch.green      = head.green;
  assign out_ch.blue       = head.blue;
  assign out_ch.column     = head.column;
  assign out_ch.row        = head.row;
  assign out_ch.frame_done = head.frame_done;

endmodule

// File: rtl/bbd_checker.sv
`timescale 1ns / 1ps

module bbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [11:0] out_column,
  input logic [11:0] out_row,
  input logic        out_frame_done
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) && $stable(out_blue)
      && $stable(out_column) && $stable(out_row) && $stable(out_frame_done))
    else $error("result payload changed while stalled");

  // a result on an empty output follows an accepted input beat through s1 and the output queue
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a matching input beat");

  // input backpressure only while results are waiting
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind bilinear_bayer_demosaic_top bbd_checker u_bbd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_red        (out_ch.red),
  .out_green      (out_ch.green),
  .out_blue       (out_ch.blue),
  .out_column     (out_ch.column),
  .out_row        (out_ch.row),
  .out_frame_done (out_ch.frame_done)
);
